// ===== hdl/scd_pkg.sv =====
`default_nettype none
package scd_pkg;

  localparam int unsigned MAX_SLICE_MBS = 32;
  localparam int unsigned QUEUE_DEPTH   = 2;
  localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned ACC_W         = 25;
  localparam logic [8:0]  IDX_NONE      = 9'h1FF;
  localparam logic [4:0]  UNARY_CAP     = 5'd31;
  localparam logic [5:0]  EG_PREFIX_CAP = 6'd17;
  localparam logic [4:0]  HDR_BITS      = 5'd5;
  localparam logic [4:0]  SKIP_HDR_BITS = 5'd4;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b0000001,
    PH_HDR     = 7'b0000010,
    PH_SKIPHDR = 7'b0000100,
    PH_PREFIX  = 7'b0001000,
    PH_SUFFIX  = 7'b0010000,
    PH_EXTRA   = 7'b0100000,
    PH_DONE    = 7'b1000000
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [1:0]  band;
    logic [4:0]  mb;
    logic [7:0]  idx;
    logic [1:0]  tsel;
    logic [15:0] val;
    logic        fin;
  } event_t;

  typedef struct packed {
    logic       ok;
    logic       neg;
    logic       wide;
    logic [7:0] base;
  } scan_row_t;

  function automatic logic [7:0] band_size(input logic [1:0] band);
    logic [7:0] s;
    case (band)
      2'd0:    s = 8'd64;
      2'd1:    s = 8'd32;
      2'd2:    s = 8'd192;
      default: s = 8'd96;
    endcase
    return s;
  endfunction

  // zigzag order inside one 4x4 block
  function automatic logic [3:0] zz4(input logic [3:0] i);
    logic [3:0] p;
    case (i)
      4'd0:  p = 4'd0;   4'd1:  p = 4'd4;   4'd2:  p = 4'd1;   4'd3:  p = 4'd2;
      4'd4:  p = 4'd5;   4'd5:  p = 4'd8;   4'd6:  p = 4'd12;  4'd7:  p = 4'd9;
      4'd8:  p = 4'd6;   4'd9:  p = 4'd3;   4'd10: p = 4'd7;   4'd11: p = 4'd10;
      4'd12: p = 4'd13;  4'd13: p = 4'd14;  4'd14: p = 4'd11;  default: p = 4'd15;
    endcase
    return p;
  endfunction

  // each 16-entry row of a scan table is base +/- block offset, row stride 4 or 8
  function automatic scan_row_t scan_row(input logic [1:0] t, input logic [3:0] row);
    scan_row_t r;
    r = '{ok: 1'b1, neg: 1'b0, wide: 1'b0, base: 8'd0};
    case ({t, row})
      {2'd0, 4'd0}:  r.base = 8'd0;
      {2'd0, 4'd1}:  begin r.neg = 1'b1; r.base = 8'd47; end
      {2'd0, 4'd2}:  r.base = 8'd16;
      {2'd0, 4'd3}:  begin r.neg = 1'b1; r.base = 8'd63; end
      {2'd1, 4'd0}:  r.base = 8'd0;
      {2'd1, 4'd1}:  begin r.neg = 1'b1; r.base = 8'd31; end
      {2'd1, 4'd2}:  r.base = 8'd32;
      {2'd1, 4'd3}:  begin r.neg = 1'b1; r.base = 8'd63; end
      {2'd2, 4'd0}:  begin r.wide = 1'b1; r.base = 8'd64; end
      {2'd2, 4'd1}:  r.base = 8'd0;
      {2'd2, 4'd2}:  r.base = 8'd16;
      {2'd2, 4'd3}:  begin r.neg = 1'b1; r.wide = 1'b1; r.base = 8'd155; end
      {2'd2, 4'd4}:  begin r.neg = 1'b1; r.base = 8'd47; end
      {2'd2, 4'd5}:  begin r.neg = 1'b1; r.base = 8'd63; end
      {2'd2, 4'd6}:  begin r.wide = 1'b1; r.base = 8'd96; end
      {2'd2, 4'd7}:  begin r.wide = 1'b1; r.base = 8'd68; end
      {2'd2, 4'd8}:  begin r.wide = 1'b1; r.base = 8'd100; end
      {2'd2, 4'd9}:  begin r.neg = 1'b1; r.wide = 1'b1; r.base = 8'd187; end
      {2'd2, 4'd10}: begin r.neg = 1'b1; r.wide = 1'b1; r.base = 8'd159; end
      {2'd2, 4'd11}: begin r.neg = 1'b1; r.wide = 1'b1; r.base = 8'd191; end
      {2'd3, 4'd0}:  begin r.wide = 1'b1; r.base = 8'd16; end
      {2'd3, 4'd1}:  r.base = 8'd0;
      {2'd3, 4'd2}:  begin r.wide = 1'b1; r.base = 8'd20; end
      {2'd3, 4'd3}:  begin r.neg = 1'b1; r.wide = 1'b1; r.base = 8'd95; end
      {2'd3, 4'd4}:  begin r.neg = 1'b1; r.base = 8'd63; end
      {2'd3, 4'd5}:  begin r.neg = 1'b1; r.wide = 1'b1; r.base = 8'd91; end
      {2'd3, 4'd6}:  begin r.wide = 1'b1; r.base = 8'd112; end
      {2'd3, 4'd7}:  r.base = 8'd96;
      {2'd3, 4'd8}:  begin r.wide = 1'b1; r.base = 8'd116; end
      {2'd3, 4'd9}:  begin r.neg = 1'b1; r.wide = 1'b1; r.base = 8'd191; end
      {2'd3, 4'd10}: begin r.neg = 1'b1; r.base = 8'd159; end
      {2'd3, 4'd11}: begin r.neg = 1'b1; r.wide = 1'b1; r.base = 8'd187; end
      default:       r.ok = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] scan_entry(input logic [1:0] t, input logic [7:0] idx);
    scan_row_t  r;
    logic [3:0] p;
    logic [7:0] off;
    r   = scan_row(t, idx[7:4]);
    p   = zz4(idx[3:0]);
    off = r.wide ? {3'b000, p[3:2], 1'b0, p[1:0]} : {4'b0000, p};
    if (!r.ok) begin
      return 8'd0;
    end
    return r.neg ? (r.base - off) : (r.base + off);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/slice_coefficient_bit_decoder.sv =====
// channel   | handshake                      | payload
// in        | in_valid_i / in_ready_o        | stream_bit_i slice_start_i slice_mbs_i
//           |                                | slice_last_bit_i
// out       | out_valid_o / out_ready_i      | result_kind_o band_number_o
//           |                                | macroblock_index_o coeff_position_o
//           |                                | coeff_value_o slice_end_o
// cfg       | cfg_valid_i / cfg_ready_o      | cfg_interlaced_mode_i
//
// one stream bit per clock while the queue has room; the bit parser finishes each bit in the cycle it is taken
// a result is written into the queue when its bit is taken, then loaded into the output
// register with its scan lookup
// a two-entry queue between parser and output stage absorbs output stalls; in_ready_o
// drops only when that queue is full
// reset is asynchronous active low and leaves the parser waiting for a slice start
`default_nettype none
module slice_coefficient_bit_decoder #(
  parameter int unsigned MaxSliceMbs = scd_pkg::MAX_SLICE_MBS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        stream_bit_i,
  input  wire logic        slice_start_i,
  input  wire logic [5:0]  slice_mbs_i,
  input  wire logic        slice_last_bit_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       result_kind_o,
  output logic [1:0]       band_number_o,
  output logic [4:0]       macroblock_index_o,
  output logic [7:0]       coeff_position_o,
  output logic [15:0]      coeff_value_o,
  output logic             slice_end_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_interlaced_mode_i
);
  import scd_pkg::*;

  logic   interlaced_q;
  logic   push_valid, push_ready, pop_valid, pop_ready;
  event_t push_ev, pop_ev;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interlaced_q <= 1'b0;
    end else if (cfg_valid_i) begin
      interlaced_q <= cfg_interlaced_mode_i;
    end
  end

  scd_front #(.MaxSliceMbs(MaxSliceMbs)) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .stream_bit_i     (stream_bit_i),
    .slice_start_i    (slice_start_i),
    .slice_mbs_i      (slice_mbs_i),
    .slice_last_bit_i (slice_last_bit_i),
    .interlaced_i     (interlaced_q),
    .push_ready_i     (push_ready),
    .push_valid_o     (push_valid),
    .push_ev_o        (push_ev)
  );

  scd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_ev_i    (push_ev),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_ev_o     (pop_ev)
  );

  scd_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ev_valid_i         (pop_valid),
    .ev_ready_o         (pop_ready),
    .ev_i               (pop_ev),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .result_kind_o      (result_kind_o),
    .band_number_o      (band_number_o),
    .macroblock_index_o (macroblock_index_o),
    .coeff_position_o   (coeff_position_o),
    .coeff_value_o      (coeff_value_o),
    .slice_end_o        (slice_end_o)
  );

endmodule
`default_nettype wire

// ===== hdl/scd_front.sv =====
`default_nettype none
module scd_front #(
  parameter int unsigned MaxSliceMbs = scd_pkg::MAX_SLICE_MBS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          stream_bit_i,
  input  wire logic          slice_start_i,
  input  wire logic [5:0]    slice_mbs_i,
  input  wire logic          slice_last_bit_i,
  input  wire logic          interlaced_i,
  input  wire logic          push_ready_i,
  output logic               push_valid_o,
  output scd_pkg::event_t    push_ev_o
);
  import scd_pkg::*;

  phase_e             phase_q, phase_d;
  logic               skip_q, skip_d;
  logic [1:0]         band_q, band_d;
  logic [4:0]         mb_q, mb_d;
  logic [8:0]         cidx_q, cidx_d;
  logic [8:0]         hdr_q, hdr_d;
  logic [4:0]         zrun_q, zrun_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [4:0]         rem_q, rem_d;
  logic [5:0]         width_q, width_d;

  logic               fire;
  logic               do_enter, do_finish, do_begin, do_endmb, do_next;
  logic [ACC_W-1:0]   enter_val, fin_val, shifted;
  logic [2:0]         extra_n;
  logic [8:0]         base;
  logic [16:0]        sum;
  logic [5:0]         mb_inc;
  logic [7:0]         num;
  event_t             ev;
  logic               ev_valid;

  assign fire         = in_valid_i & push_ready_i;
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = fire & ev_valid;
  assign push_ev_o    = ev;

  always_comb begin
    phase_d = phase_q; skip_d = skip_q; band_d = band_q; mb_d = mb_q; cidx_d = cidx_q;
    hdr_d = hdr_q; zrun_d = zrun_q; acc_d = acc_q; rem_d = rem_q; width_d = width_q;
    ev = '0;
    ev.kind = KIND_WRITE;
    ev_valid = 1'b0;
    do_enter = 1'b0; do_finish = 1'b0; do_begin = 1'b0; do_endmb = 1'b0; do_next = 1'b0;
    enter_val = '0; fin_val = '0;
    extra_n = 3'd0; base = 9'd0; sum = 17'd0; mb_inc = 6'd0;
    num = band_size(band_q);
    shifted = {acc_q[ACC_W-2:0], stream_bit_i};
    if (fire) begin
      if (slice_start_i) begin
        width_d = (slice_mbs_i > 6'(MaxSliceMbs)) ? 6'(MaxSliceMbs) : slice_mbs_i;
        band_d = 2'd0; mb_d = 5'd0; cidx_d = IDX_NONE; hdr_d = 9'd0; zrun_d = 5'd0;
        acc_d = '0; rem_d = HDR_BITS; phase_d = PH_HDR; skip_d = 1'b0;
        shifted = {{(ACC_W-1){1'b0}}, stream_bit_i};
      end
      if (phase_d != PH_IDLE && phase_d != PH_DONE) begin
        case (phase_d)
          PH_HDR: begin
            hdr_d = {hdr_d[7:0], stream_bit_i};
            rem_d = rem_d - 5'd1;
            if (rem_d == 5'd0) begin
              if (hdr_d[4]) begin
                rem_d   = SKIP_HDR_BITS;
                phase_d = PH_SKIPHDR;
              end else begin
                hdr_d    = {hdr_d[4:0], 4'b0000};
                do_begin = 1'b1;
              end
            end
          end
          PH_SKIPHDR: begin
            hdr_d = {hdr_d[7:0], stream_bit_i};
            rem_d = rem_d - 5'd1;
            if (rem_d == 5'd0) begin
              do_begin = 1'b1;
            end
          end
          PH_PREFIX: begin
            if (!(skip_d ? hdr_d[3] : hdr_d[7])) begin
              // unary, capped without terminator
              if (stream_bit_i) begin
                do_enter  = 1'b1;
                enter_val = ACC_W'(zrun_d);
              end else begin
                zrun_d = zrun_d + 5'd1;
                if (zrun_d == UNARY_CAP) begin
                  do_enter  = 1'b1;
                  enter_val = ACC_W'(UNARY_CAP);
                end
              end
            end else if (stream_bit_i) begin
              if (zrun_d == 5'd0) begin
                do_enter = 1'b1;
              end else begin
                rem_d   = zrun_d;
                acc_d   = ACC_W'(1);
                phase_d = PH_SUFFIX;
              end
            end else begin
              zrun_d = zrun_d + 5'd1;
              if ({1'b0, zrun_d} == EG_PREFIX_CAP) begin
                ev       = '0;
                ev.kind  = KIND_ERROR;
                ev.fin   = 1'b1;
                ev_valid = 1'b1;
                phase_d  = PH_DONE;
              end
            end
          end
          PH_SUFFIX: begin
            acc_d = shifted;
            rem_d = rem_d - 5'd1;
            if (rem_d == 5'd0) begin
              do_enter  = 1'b1;
              enter_val = shifted - ACC_W'(1);
            end
          end
          PH_EXTRA: begin
            acc_d = shifted;
            rem_d = rem_d - 5'd1;
            if (rem_d == 5'd0) begin
              do_finish = 1'b1;
              fin_val   = shifted;
            end
          end
          default: phase_d = PH_DONE;
        endcase

        if (do_enter) begin
          extra_n = skip_d ? hdr_d[2:0] : hdr_d[6:4];
          acc_d   = enter_val;
          if (extra_n == 3'd0) begin
            do_finish = 1'b1;
            fin_val   = enter_val;
          end else begin
            rem_d   = {2'b00, extra_n};
            phase_d = PH_EXTRA;
          end
        end

        if (do_finish) begin
          if (skip_d) begin
            if (|fin_val[ACC_W-1:16]) begin
              ev = '0; ev.kind = KIND_ERROR; ev.fin = 1'b1; ev_valid = 1'b1;
              phase_d = PH_DONE;
            end else begin
              base = (cidx_d == IDX_NONE) ? 9'd0 : cidx_d + 9'd1;
              sum  = 17'(base) + {1'b0, fin_val[15:0]};
              if (sum >= 17'(num)) begin
                do_endmb = 1'b1;
              end else begin
                cidx_d  = sum[8:0];
                phase_d = PH_PREFIX; skip_d = 1'b0; zrun_d = 5'd0; acc_d = '0;
              end
            end
          end else if ((hdr_d[8] && fin_val >= ACC_W'(17'hFFFF)) || (|fin_val[ACC_W-1:16])) begin
            ev = '0; ev.kind = KIND_ERROR; ev.fin = 1'b1; ev_valid = 1'b1;
            phase_d = PH_DONE;
          end else begin
            ev_valid = 1'b1;
            ev.kind  = KIND_WRITE;
            ev.band  = band_d;
            ev.mb    = mb_d;
            ev.idx   = cidx_d[7:0];
            ev.tsel  = band_d | {1'b0, ~interlaced_i};
            ev.val   = hdr_d[8] ? (fin_val[15:0] + 16'd1) : fin_val[15:0];
            ev.fin   = 1'b0;
            if ({1'b0, cidx_d} + 10'd1 >= 10'(num)) begin
              do_endmb = 1'b1;
            end else begin
              if (!hdr_d[8]) begin
                cidx_d = cidx_d + 9'd1;
              end
              phase_d = PH_PREFIX; skip_d = hdr_d[8]; zrun_d = 5'd0; acc_d = '0;
            end
          end
        end

        if (do_begin) begin
          mb_d = 5'd0;
          if (width_d == 6'd0) begin
            do_next = 1'b1;
          end else begin
            cidx_d  = hdr_d[8] ? IDX_NONE : 9'd0;
            phase_d = PH_PREFIX; skip_d = hdr_d[8]; zrun_d = 5'd0; acc_d = '0;
          end
        end

        if (do_endmb) begin
          mb_inc = {1'b0, mb_d} + 6'd1;
          if (mb_inc >= width_d) begin
            do_next = 1'b1;
          end else begin
            mb_d    = mb_inc[4:0];
            cidx_d  = hdr_d[8] ? IDX_NONE : 9'd0;
            phase_d = PH_PREFIX; skip_d = hdr_d[8]; zrun_d = 5'd0; acc_d = '0;
          end
        end

        if (do_next) begin
          if (band_d == 2'd3) begin
            phase_d = PH_DONE;
            if (!ev_valid) begin
              ev       = '0;
              ev.kind  = KIND_DONE;
              ev_valid = 1'b1;
            end
            ev.fin = 1'b1;
          end else begin
            band_d  = band_d + 2'd1;
            hdr_d   = 9'd0;
            rem_d   = HDR_BITS;
            phase_d = PH_HDR;
            skip_d  = 1'b0;
          end
        end

        // slice data ran out before decoding finished
        if (slice_last_bit_i && phase_d != PH_DONE) begin
          ev = '0; ev.kind = KIND_ERROR; ev.fin = 1'b1; ev_valid = 1'b1;
          phase_d = PH_DONE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      skip_q  <= 1'b0;
      band_q  <= 2'd0;
      mb_q    <= 5'd0;
      cidx_q  <= IDX_NONE;
      hdr_q   <= 9'd0;
      zrun_q  <= 5'd0;
      acc_q   <= '0;
      rem_q   <= 5'd0;
      width_q <= 6'd0;
    end else begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      band_q  <= band_d;
      mb_q    <= mb_d;
      cidx_q  <= cidx_d;
      hdr_q   <= hdr_d;
      zrun_q  <= zrun_d;
      acc_q   <= acc_d;
      rem_q   <= rem_d;
      width_q <= width_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/scd_queue.sv =====
`default_nettype none
module scd_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  wire scd_pkg::event_t push_ev_i,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i,
  output scd_pkg::event_t    pop_ev_o
);
  import scd_pkg::*;

  event_t             entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wptr_q, rptr_q;
  logic [QCNT_W-1:0]  count_q;
  logic               do_push, do_pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_ev_o     = entry_q[rptr_q];
  assign do_push      = push_valid_i & push_ready_o;
  assign do_pop       = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= push_ev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/scd_back.sv =====
`default_nettype none
module scd_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            ev_valid_i,
  output logic                 ev_ready_o,
  input  wire scd_pkg::event_t ev_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [1:0]           result_kind_o,
  output logic [1:0]           band_number_o,
  output logic [4:0]           macroblock_index_o,
  output logic [7:0]           coeff_position_o,
  output logic [15:0]          coeff_value_o,
  output logic                 slice_end_o
);
  import scd_pkg::*;

  logic        valid_q;
  logic [1:0]  kind_q;
  logic [1:0]  band_q;
  logic [4:0]  mb_q;
  logic [7:0]  pos_q, pos_d;
  logic [15:0] val_q;
  logic        end_q;
  logic        load;

  assign ev_ready_o = !valid_q || out_ready_i;
  assign load       = ev_valid_i && ev_ready_o;
  assign pos_d      = (ev_i.kind == KIND_WRITE) ? scan_entry(ev_i.tsel, ev_i.idx) : 8'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ev_ready_o) begin
      valid_q <= ev_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= ev_i.kind;
      band_q <= ev_i.band;
      mb_q   <= ev_i.mb;
      pos_q  <= pos_d;
      val_q  <= ev_i.val;
      end_q  <= ev_i.fin;
    end
  end

  assign out_valid_o        = valid_q;
  assign result_kind_o      = kind_q;
  assign band_number_o      = band_q;
  assign macroblock_index_o = mb_q;
  assign coeff_position_o   = pos_q;
  assign coeff_value_o      = val_q;
  assign slice_end_o        = end_q;

endmodule
`default_nettype wire

// ===== hdl/scd_checker.sv =====
`default_nettype none
module scd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [1:0]  result_kind_o,
  input wire logic [1:0]  band_number_o,
  input wire logic [4:0]  macroblock_index_o,
  input wire logic [7:0]  coeff_position_o,
  input wire logic [15:0] coeff_value_o,
  input wire logic        slice_end_o
);
  import scd_pkg::*;

  // a waiting result is not withdrawn
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // slice finish and error always close the slice
  a_nonwrite_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != KIND_WRITE |-> slice_end_o)
    else $error("finish or error without slice end");

  a_nonwrite_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != KIND_WRITE |->
      band_number_o == 2'd0 && macroblock_index_o == 5'd0 &&
      coeff_position_o == 8'd0 && coeff_value_o == 16'd0)
    else $error("non-write result carries payload");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == KIND_WRITE |-> coeff_position_o < 8'd192)
    else $error("scan position out of band area");

endmodule

bind slice_coefficient_bit_decoder scd_checker u_scd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .result_kind_o      (result_kind_o),
  .band_number_o      (band_number_o),
  .macroblock_index_o (macroblock_index_o),
  .coeff_position_o   (coeff_position_o),
  .coeff_value_o      (coeff_value_o),
  .slice_end_o        (slice_end_o)
);
`default_nettype wire
